### src/raster_circle_generator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the circle rasteriser checker.
// ---------------------------------------------------------------------------
`ifndef RASTER_CIRCLE_GENERATOR_ASSERT_SVH
`define RASTER_CIRCLE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RCG_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rcg checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define RCG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rcg checker: next-cycle property failed");

`endif

### src/rcg_pkg.sv
// ---------------------------------------------------------------------------
// rcg_pkg
// Shared types and constants of the midpoint circle rasteriser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcg_pkg;

  localparam int RADIUS_BITS = 11;

  localparam int COORD_W = 16;               // centre and screen size
  localparam int POS_W   = 17;               // result coordinates
  localparam int CALC_W  = 18;               // internal coordinate maths
  localparam int RAD_W   = 11;               // radius port
  localparam int COLOR_W = 32;
  localparam int KIND_W  = 2;
  localparam int X_W     = RADIUS_BITS + 1;  // step x, unsigned
  localparam int Y_W     = RADIUS_BITS + 2;  // step y, signed, reaches -1
  localparam int D_W     = RADIUS_BITS + 5;  // decision term, signed
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPAN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd2;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 16'd640;
  localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 16'd480;

  typedef enum logic [1:0] {
    JOB_IDLE,
    JOB_OUTLINE,
    JOB_FILL
  } job_mode_t;

  // Snapshot of one iteration, handed from the tracker to the emitter.
  typedef struct packed {
    job_mode_t                  mode;
    logic signed [COORD_W-1:0]  ox;
    logic signed [COORD_W-1:0]  oy;
    logic        [X_W-1:0]      x;
    logic signed [Y_W-1:0]      y;
    logic        [COLOR_W-1:0]  color;
    logic                       done;
  } job_t;

endpackage

`default_nettype wire

### src/raster_circle_generator.sv
// ---------------------------------------------------------------------------
// raster_circle_generator
// Midpoint circle rasteriser: points or clipped spans, one iteration a step.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | mode, centre, radius, fill, colour
//  out_    | output    | out_valid / out_stall| kind, visible, x range, row, flags
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
//  A start request gives no result.
//  A step request gives 4 results (outline), 2 (fill) or 1 (idle), one a
//  cycle through the output register while out_stall is low.
//  The next request is taken in the cycle the last result leaves the emitter.
//  out_stall holds the output register and, once the emitter is full, in_stall.
//  Synchronous reset; screen size resets to 640 x 480.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raster_circle_generator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_mode,
  input  wire signed [rcg_pkg::COORD_W-1:0]   in_center_x,
  input  wire signed [rcg_pkg::COORD_W-1:0]   in_center_y,
  input  wire        [rcg_pkg::RAD_W-1:0]     in_radius,
  input  wire                                 in_fill,
  input  wire        [rcg_pkg::COLOR_W-1:0]   in_color,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic       [rcg_pkg::KIND_W-1:0]    out_kind,
  output logic                                out_visible,
  output logic signed [rcg_pkg::POS_W-1:0]    out_left_x,
  output logic signed [rcg_pkg::POS_W-1:0]    out_right_x,
  output logic signed [rcg_pkg::POS_W-1:0]    out_row_y,
  output logic       [rcg_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                                out_last,
  output logic                                out_done_res,
  input  wire                                 cfg_we,
  input  wire        [rcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [rcg_pkg::COORD_W-1:0]   cfg_data
);
  import rcg_pkg::*;

  logic [COORD_W-1:0] width_r, height_r;
  logic               accept, busy;
  job_t               job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SCREEN_WIDTH;
      height_r <= RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  rcg_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .mode     (in_mode),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .fill     (in_fill),
    .color    (in_color),
    .job      (job)
  );

  rcg_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (accept && in_mode == MODE_STEP),
    .job_in          (job),
    .screen_width    (width_r),
    .screen_height   (height_r),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_visible     (out_visible),
    .out_left_x      (out_left_x),
    .out_right_x     (out_right_x),
    .out_row_y       (out_row_y),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .out_done_res    (out_done_res)
  );

endmodule

`default_nettype wire

### src/rcg_tracker.sv
// ---------------------------------------------------------------------------
// rcg_tracker
// Circle state and midpoint decision update, one iteration per step request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcg_tracker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           accept,
  input  wire                           mode,
  input  wire signed [rcg_pkg::COORD_W-1:0] center_x,
  input  wire signed [rcg_pkg::COORD_W-1:0] center_y,
  input  wire        [rcg_pkg::RAD_W-1:0]   radius,
  input  wire                           fill,
  input  wire        [rcg_pkg::COLOR_W-1:0] color,
  output rcg_pkg::job_t                 job
);
  import rcg_pkg::*;

  localparam int E_W = D_W + 2;
  localparam logic signed [E_W-1:0] ONE_E = E_W'(1);

  logic        [X_W-1:0]     x_r, x_nxt;
  logic signed [Y_W-1:0]     y_r, y_nxt;
  logic signed [D_W-1:0]     d_r, d_nxt;
  logic signed [COORD_W-1:0] ox_r, oy_r;
  logic        [COLOR_W-1:0] color_r;
  logic                      fill_r;
  logic                      active_r, active_nxt;

  logic        [RADIUS_BITS-1:0] rad;
  logic signed [E_W-1:0]     d_e, y_e, x_e, x1_e, y1_e, err, d_step;
  logic        [X_W-1:0]     x_step;
  logic signed [Y_W-1:0]     y_step;

  always_comb begin
    rad  = RADIUS_BITS'(radius);
    d_e  = E_W'(d_r);
    y_e  = E_W'(y_r);
    x_e  = $signed(E_W'(x_r));
    x1_e = x_e + ONE_E;
    y1_e = y_e - ONE_E;
    err  = ((d_e + y_e) <<< 1) - ONE_E;

    if (d_e < 0 && err <= 0) begin
      x_step = x_r + X_W'(1);
      y_step = y_r;
      d_step = d_e + (x1_e <<< 1) + ONE_E;
    end else if (d_e > 0 && err > 0) begin
      x_step = x_r;
      y_step = y_r - Y_W'(1);
      d_step = d_e - ((y1_e <<< 1) + ONE_E);
    end else begin
      x_step = x_r + X_W'(1);
      y_step = y_r - Y_W'(1);
      d_step = d_e + ((x1_e - y_e) <<< 1);
    end

    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    if (accept) begin
      if (mode == MODE_START) begin
        x_nxt      = '0;
        y_nxt      = $signed(Y_W'(rad));
        d_nxt      = D_W'(1) - (D_W'(rad) <<< 1);
        active_nxt = 1'b1;
      end else if (active_r) begin
        x_nxt      = x_step;
        y_nxt      = y_step;
        d_nxt      = D_W'(d_step);
        active_nxt = !y_step[Y_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '1;
      d_r      <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      color_r  <= '0;
      fill_r   <= 1'b0;
      active_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
      if (accept && mode == MODE_START) begin
        ox_r    <= center_x;
        oy_r    <= center_y;
        color_r <= color;
        fill_r  <= fill;
      end
    end
  end

  // Snapshot of the current iteration, taken by the emitter on a step
  always_comb begin
    job.mode  = !active_r ? JOB_IDLE : (fill_r ? JOB_FILL : JOB_OUTLINE);
    job.ox    = ox_r;
    job.oy    = oy_r;
    job.x     = x_r;
    job.y     = y_r;
    job.color = color_r;
    job.done  = !active_r || y_step[Y_W-1];
  end

endmodule

`default_nettype wire

### src/rcg_emitter.sv
// ---------------------------------------------------------------------------
// rcg_emitter
// Walks the results of one iteration into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcg_emitter (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               load,
  input  wire        rcg_pkg::job_t         job_in,
  input  wire        [rcg_pkg::COORD_W-1:0] screen_width,
  input  wire        [rcg_pkg::COORD_W-1:0] screen_height,
  output logic                              busy,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic       [rcg_pkg::KIND_W-1:0]  out_kind,
  output logic                              out_visible,
  output logic signed [rcg_pkg::POS_W-1:0]  out_left_x,
  output logic signed [rcg_pkg::POS_W-1:0]  out_right_x,
  output logic signed [rcg_pkg::POS_W-1:0]  out_row_y,
  output logic       [rcg_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                              out_last,
  output logic                              out_done_res
);
  import rcg_pkg::*;

  job_t       job_r;
  logic       job_valid_r;
  logic [1:0] idx_r;

  logic                     out_valid_r;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic                     vis_r, vis_nxt;
  logic signed [POS_W-1:0]  left_r, left_nxt, right_r, right_nxt, row_r, row_nxt;
  logic [COLOR_W-1:0]       color_r, color_nxt;
  logic                     last_r, last_nxt, done_r, done_nxt;

  logic                     take, adv, job_last;
  logic [1:0]               last_idx;
  logic signed [CALC_W-1:0] ox, oy, xe, ye, w, h, wm1;
  logic signed [CALC_W-1:0] px, py, sl, sr, cl, cr;
  logic                     row_on, col_on;

  assign take = !out_valid_r || !out_stall;
  assign adv  = job_valid_r && take;

  always_comb begin
    case (job_r.mode)
      JOB_OUTLINE: last_idx = 2'd3;
      JOB_FILL:    last_idx = 2'd1;
      default:     last_idx = 2'd0;
    endcase
  end

  assign job_last = (idx_r == last_idx);
  // Free for a new request in the cycle the final result moves out
  assign busy = job_valid_r && !(adv && job_last);

  always_comb begin
    ox  = CALC_W'(job_r.ox);
    oy  = CALC_W'(job_r.oy);
    xe  = $signed(CALC_W'(job_r.x));
    ye  = CALC_W'(job_r.y);
    w   = $signed(CALC_W'(screen_width));
    h   = $signed(CALC_W'(screen_height));
    wm1 = w - CALC_W'(1);

    // outline order: (+x,+y) (+x,-y) (-x,+y) (-x,-y); spans use bit 0 for row
    px = idx_r[1] ? (ox - xe) : (ox + xe);
    py = idx_r[0] ? (oy - ye) : (oy + ye);
    sl = ox - xe;
    sr = ox + xe;
    cl = (sl < 0) ? '0 : sl;
    cr = (sr > wm1) ? wm1 : sr;

    row_on = (py >= 0) && (py < h);
    col_on = (px >= 0) && (px < w);

    color_nxt = job_r.color;
    row_nxt   = POS_W'(py);
    last_nxt  = job_last;
    done_nxt  = job_last && job_r.done;
    case (job_r.mode)
      JOB_OUTLINE: begin
        kind_nxt  = KIND_POINT;
        vis_nxt   = row_on && col_on;
        left_nxt  = POS_W'(px);
        right_nxt = POS_W'(px);
      end
      JOB_FILL: begin
        kind_nxt = KIND_SPAN;
        vis_nxt  = row_on && (cl <= cr);
        if (vis_nxt) begin
          left_nxt  = POS_W'(cl);
          right_nxt = POS_W'(cr);
        end else begin
          left_nxt  = POS_W'(sl);
          right_nxt = POS_W'(sr);
        end
      end
      default: begin
        kind_nxt  = KIND_IDLE;
        vis_nxt   = 1'b0;
        left_nxt  = '0;
        right_nxt = '0;
        row_nxt   = '0;
        color_nxt = '0;
        last_nxt  = 1'b1;
        done_nxt  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (adv) begin
        if (job_last) begin
          job_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (take) begin
        out_valid_r <= job_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
    if (take) begin
      kind_r  <= kind_nxt;
      vis_r   <= vis_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
      last_r  <= last_nxt;
      done_r  <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_visible     = vis_r;
  assign out_left_x      = left_r;
  assign out_right_x     = right_r;
  assign out_row_y       = row_r;
  assign out_pixel_color = color_r;
  assign out_last        = last_r;
  assign out_done_res    = done_r;

endmodule

`default_nettype wire

### src/rcg_checker.sv
// ---------------------------------------------------------------------------
// rcg_checker
// Port-level properties of the circle rasteriser, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "raster_circle_generator_assert.svh"

module rcg_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire        [rcg_pkg::KIND_W-1:0]    out_kind,
  input wire                                 out_visible,
  input wire signed [rcg_pkg::POS_W-1:0]     out_left_x,
  input wire signed [rcg_pkg::POS_W-1:0]     out_right_x,
  input wire                                 out_last,
  input wire                                 out_done_res
);
  import rcg_pkg::*;

  // held result stays put
  `RCG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_left_x) && $stable(out_kind))
  // only the closing result of a request may report the circle finished
  `RCG_ASSERT_NOW(a_done_on_last, clk, rst_n, out_valid && !out_last, !out_done_res)
  // a point has one column
  `RCG_ASSERT_NOW(a_point_width, clk, rst_n, out_valid && out_kind == KIND_POINT, out_left_x == out_right_x)
  // idle answer is a lone, finished, invisible result
  `RCG_ASSERT_NOW(a_idle_shape, clk, rst_n, out_valid && out_kind == KIND_IDLE, out_last && out_done_res && !out_visible)

endmodule

bind raster_circle_generator rcg_checker u_rcg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_kind     (out_kind),
  .out_visible  (out_visible),
  .out_left_x   (out_left_x),
  .out_right_x  (out_right_x),
  .out_last     (out_last),
  .out_done_res (out_done_res)
);

`default_nettype wire
